/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/core/gss_pkg.sv */
package gss_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int GRID_MAX  = 1024;
    localparam int CNT_W     = 10;
    localparam int GRID_W    = 11;
    localparam int SHIFT_W   = 20;
    localparam int SCALE_W   = 32;
    localparam int DEPTH_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int HORNER_N  = 11;
    localparam int SQ_STEPS  = 31;
    localparam int CC_W      = 31;
    localparam int REM_W     = 34;

    localparam logic [CC_W-1:0]    Q30_ONE   = 31'h4000_0000;
    localparam logic [29:0]        LN2_Q30   = 30'd744261118;
    localparam logic [28:0]        T_LIMIT   = 29'h1000_0000;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIZE = 3'd0,
        REG_X_SHIFT   = 3'd1,
        REG_Y_SHIFT   = 3'd2,
        REG_EXP_SCALE = 3'd3,
        REG_DEPTH     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_re;
        logic signed [SAMPLE_W-1:0] out_im;
        logic                       frame_end;
    } out_t;

    typedef struct packed {
        logic [GRID_W-1:0]         grid_size;
        logic signed [SHIFT_W-1:0] x_shift;
        logic signed [SHIFT_W-1:0] y_shift;
        logic [SCALE_W-1:0]        exp_scale;
        logic [DEPTH_W-1:0]        depth;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        grid_size: 11'd256,
        x_shift:   20'sd0,
        y_shift:   20'sd0,
        exp_scale: 32'd16777216,
        depth:     16'd16384
    };

    typedef struct packed {
        in_t  smp;
        logic last;
    } tag_t;

    typedef struct packed {
        logic [29:0] r;
        logic [4:0]  k;
        logic        zero;
        tag_t        tag;
    } exp_ctx_t;

    // floor(m / n) = (m * magic) >> shift for m below 2^30
    function automatic logic [31:0] hdiv_magic(input int n);
        case (n)
            3:       return 32'd1431655766;
            5:       return 32'd1717986919;
            6:       return 32'd1431655766;
            7:       return 32'd1227133514;
            9:       return 32'd1908874354;
            10:      return 32'd1717986919;
            11:      return 32'd1561806290;
            default: return 32'd1;
        endcase
    endfunction

    function automatic int hdiv_shift(input int n);
        case (n)
            2:       return 1;
            3:       return 32;
            4:       return 2;
            5, 6, 7: return 33;
            8:       return 3;
            9, 10, 11: return 34;
            default: return 0;
        endcase
    endfunction

endpackage

/* rtl/core/gss_front.sv */
module gss_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  gss_pkg::in_t      in_smp,
    input  gss_pkg::cfg_t     cfg,
    output logic              out_vld,
    output gss_pkg::exp_ctx_t out_ctx
);
    import gss_pkg::*;

    logic [CNT_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [GRID_W-1:0] n_eff, n_m1;
    logic [CNT_W-1:0]  half;
    logic              last_col, last_row, enter;
    logic signed [21:0] x_c, y_c;

    // stage registers
    logic               v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    tag_t               t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    logic signed [21:0] x0_reg, y0_reg;
    logic [39:0]        sqx1_reg, sqy1_reg;
    logic [40:0]        s2_reg;
    logic [48:0]        ph3_reg;
    logic [55:0]        pl3_reg;
    logic [28:0]        t24_4_reg;
    logic               over4_reg, over5_reg, over6_reg;
    logic [34:0]        t30_5_reg;
    logic [4:0]         k5_reg, k6_reg;
    logic [29:0]        r6_reg;

    logic signed [43:0] sqx_c, sqy_c;
    logic [48:0]        ph_c;
    logic [55:0]        pl_c;
    logic [72:0]        p_c;
    logic [34:0]        t30_c, kln_c, r_c;
    logic [4:0]         k_c;

    always_comb
    begin
        if (cfg.grid_size < GRID_W'(2))
            n_eff = GRID_W'(2);
        else if (cfg.grid_size > GRID_W'(GRID_MAX))
            n_eff = GRID_W'(GRID_MAX);
        else
            n_eff = cfg.grid_size;
        n_m1     = n_eff - GRID_W'(1);
        half     = n_eff[GRID_W-1:1];
        last_col = {1'b0, col_reg} >= n_m1;
        last_row = {1'b0, row_reg} >= n_m1;
        enter    = en && in_vld;
        col_next = col_reg;
        row_next = row_reg;
        if (enter)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        x_c = $signed({4'b0, row_reg, 8'b0}) - $signed({4'b0, half, 8'b0})
            - $signed({{2{cfg.x_shift[SHIFT_W-1]}}, cfg.x_shift});
        y_c = $signed({4'b0, col_reg, 8'b0}) - $signed({4'b0, half, 8'b0})
            - $signed({{2{cfg.y_shift[SHIFT_W-1]}}, cfg.y_shift});
    end

    always_comb
    begin
        sqx_c = x0_reg * x0_reg;
        sqy_c = y0_reg * y0_reg;
        ph_c  = 49'(s2_reg[40:24]) * 49'(cfg.exp_scale);
        pl_c  = 56'(s2_reg[23:0]) * 56'(cfg.exp_scale);
        p_c   = {ph3_reg, 24'b0} + 73'(pl3_reg);
        t30_c = {t24_4_reg, 6'b0};
        // thresholds rise monotonically, so the last hit is k
        k_c   = '0;
        for (int j = 1; j < 24; j++)
        begin
            if (t30_c >= 35'(j) * 35'(LN2_Q30))
                k_c = 5'(j);
        end
        kln_c = 35'(k5_reg) * 35'(LN2_Q30);
        r_c   = t30_5_reg - kln_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
        end
        else if (en)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            v0_reg  <= in_vld;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg    <= x_c;
            y0_reg    <= y_c;
            t0_reg    <= '{smp: in_smp, last: last_col && last_row};
            sqx1_reg  <= sqx_c[39:0];
            sqy1_reg  <= sqy_c[39:0];
            t1_reg    <= t0_reg;
            s2_reg    <= 41'(sqx1_reg) + 41'(sqy1_reg);
            t2_reg    <= t1_reg;
            ph3_reg   <= ph_c;
            pl3_reg   <= pl_c;
            t3_reg    <= t2_reg;
            t24_4_reg <= p_c[44:16];
            over4_reg <= (|p_c[72:45]) || (p_c[44:16] > T_LIMIT);
            t4_reg    <= t3_reg;
            t30_5_reg <= t30_c;
            k5_reg    <= k_c;
            over5_reg <= over4_reg;
            t5_reg    <= t4_reg;
            r6_reg    <= r_c[29:0];
            k6_reg    <= k5_reg;
            over6_reg <= over5_reg;
            t6_reg    <= t5_reg;
        end
    end

    assign out_vld = v6_reg;
    assign out_ctx = '{r: r6_reg, k: k6_reg, zero: over6_reg, tag: t6_reg};

endmodule

/* rtl/core/gss_hstep.sv */
module gss_hstep #(
    parameter int N = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  gss_pkg::exp_ctx_t in_ctx,
    input  logic [30:0]       in_p,
    output logic              out_vld,
    output gss_pkg::exp_ctx_t out_ctx,
    output logic [30:0]       out_p
);
    import gss_pkg::*;

    localparam logic [31:0] MAG = hdiv_magic(N);
    localparam int          SH  = hdiv_shift(N);

    logic        va_reg, vb_reg;
    exp_ctx_t    ca_reg, cb_reg;
    logic [29:0] m_reg;
    logic [30:0] p_reg;
    logic [60:0] rp_c;
    logic [61:0] qm_c;
    logic [30:0] q_c;

    always_comb
    begin
        rp_c = 61'(in_ctx.r) * 61'(in_p);
        qm_c = 62'(m_reg) * 62'(MAG);
        q_c  = 31'(qm_c >> SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_vld;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg  <= rp_c[59:30];
            ca_reg <= in_ctx;
            p_reg  <= Q30_ONE - q_c;
            cb_reg <= ca_reg;
        end
    end

    assign out_vld = vb_reg;
    assign out_ctx = cb_reg;
    assign out_p   = p_reg;

endmodule

/* rtl/core/gss_sqstep.sv */
module gss_sqstep #(
    parameter int I = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic [gss_pkg::REM_W-1:0] in_rem,
    input  logic [gss_pkg::CC_W-1:0]  in_root,
    input  logic [gss_pkg::CC_W-1:0]  in_v,
    input  gss_pkg::tag_t             in_tag,
    output logic                      out_vld,
    output logic [gss_pkg::REM_W-1:0] out_rem,
    output logic [gss_pkg::CC_W-1:0]  out_root,
    output logic [gss_pkg::CC_W-1:0]  out_v,
    output gss_pkg::tag_t             out_tag
);
    import gss_pkg::*;

    localparam int POS = 61 - 2 * I;

    logic             vld_reg;
    logic [REM_W-1:0] rem_reg, rem_sh, trial, rem_c;
    logic [CC_W-1:0]  root_reg, root_c, v_reg;
    logic [61:0]      rad;
    tag_t             tag_reg;

    // radicand is v * 2^30, two bits consumed per stage
    always_comb
    begin
        rad    = {1'b0, in_v, 30'b0};
        rem_sh = {in_rem[REM_W-3:0], rad[POS -: 2]};
        trial  = {1'b0, in_root, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_c  = rem_sh - trial;
            root_c = {in_root[CC_W-2:0], 1'b1};
        end
        else
        begin
            rem_c  = rem_sh;
            root_c = {in_root[CC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_c;
            root_reg <= root_c;
            v_reg    <= in_v;
            tag_reg  <= in_tag;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;
    assign out_v    = v_reg;
    assign out_tag  = tag_reg;

endmodule

/* rtl/core/gss_scale.sv */
module gss_scale (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic [gss_pkg::CC_W-1:0] in_cc,
    input  gss_pkg::tag_t            in_tag,
    output logic                     out_vld,
    output gss_pkg::out_t            out_data
);
    import gss_pkg::*;

    localparam int PROD_W = SAMPLE_W + CC_W;
    localparam logic [PROD_W-1:0] RND = PROD_W'(1) << 29;

    logic [SAMPLE_W-1:0] mag_re, mag_im, q_re, q_im;
    logic [PROD_W-1:0]   pre_reg, pim_reg, rre_c, rim_c;
    logic                nre_reg, nim_reg, last_reg, mv_reg, ov_reg;
    out_t                res_reg;

    always_comb
    begin
        mag_re = in_tag.smp.sample_re[SAMPLE_W-1] ? SAMPLE_W'(-in_tag.smp.sample_re)
                                                   : SAMPLE_W'(in_tag.smp.sample_re);
        mag_im = in_tag.smp.sample_im[SAMPLE_W-1] ? SAMPLE_W'(-in_tag.smp.sample_im)
                                                   : SAMPLE_W'(in_tag.smp.sample_im);
        // round half away from zero on the magnitude
        rre_c  = pre_reg + RND;
        rim_c  = pim_reg + RND;
        q_re   = rre_c[30 +: SAMPLE_W];
        q_im   = rim_c[30 +: SAMPLE_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            mv_reg <= in_vld;
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg           <= PROD_W'(mag_re) * PROD_W'(in_cc);
            pim_reg           <= PROD_W'(mag_im) * PROD_W'(in_cc);
            nre_reg           <= in_tag.smp.sample_re[SAMPLE_W-1];
            nim_reg           <= in_tag.smp.sample_im[SAMPLE_W-1];
            last_reg          <= in_tag.last;
            res_reg.out_re    <= nre_reg ? -q_re : q_re;
            res_reg.out_im    <= nim_reg ? -q_im : q_im;
            res_reg.frame_end <= last_reg;
        end
    end

    assign out_vld  = ov_reg;
    assign out_data = res_reg;

endmodule

/* rtl/core/gaussian_screen_field_scaler.sv */
// channel  | beat signals                          | direction
// sample   | sample_valid, sample_stall, sample    | in
// result   | result_valid, result_stall, result    | out
// cfg      | cfg_valid, cfg_ready, cfg_index/data  | in
//
// One pixel per cycle while no result stall holds the pipeline.
// Most of the depth comes from the 31-stage square root and the 11 two-stage Horner steps.
// Reset clears valid bits, pixel counters and loads the register defaults.
// A result stall freezes the whole pipeline; one input beat is caught in a
// skid register, so sample_stall is a registered signal.
`include "assert_macros.svh"

module gaussian_screen_field_scaler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  gss_pkg::in_t                  sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output gss_pkg::out_t                 result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gss_pkg::CFG_DAT_W-1:0] cfg_data
);
    import gss_pkg::*;

    cfg_t cfg_reg;
    logic adv, accept, src_vld;
    logic skid_full_reg;
    in_t  skid_reg, src;
    logic [DEPTH_W-1:0] d_eff;

    logic     h_vld [0:HORNER_N];
    exp_ctx_t h_ctx [0:HORNER_N];
    logic [30:0] h_p [0:HORNER_N];

    logic        e_vld_reg, de_vld_reg, v_vld_reg;
    logic [30:0] e_reg, v_reg;
    logic [31:0] de_reg;
    tag_t        e_tag_reg, de_tag_reg, v_tag_reg;
    logic [46:0] de_c;

    logic             sq_vld  [0:SQ_STEPS];
    logic [REM_W-1:0] sq_rem  [0:SQ_STEPS];
    logic [CC_W-1:0]  sq_root [0:SQ_STEPS];
    logic [CC_W-1:0]  sq_v    [0:SQ_STEPS];
    tag_t             sq_tag  [0:SQ_STEPS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_GRID_SIZE: cfg_reg.grid_size <= cfg_data[GRID_W-1:0];
                REG_X_SHIFT:   cfg_reg.x_shift   <= cfg_data[SHIFT_W-1:0];
                REG_Y_SHIFT:   cfg_reg.y_shift   <= cfg_data[SHIFT_W-1:0];
                REG_EXP_SCALE: cfg_reg.exp_scale <= cfg_data[SCALE_W-1:0];
                REG_DEPTH:     cfg_reg.depth     <= cfg_data[DEPTH_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // pipeline moves unless a finished result is held by the sink
    assign adv          = !(result_valid && result_stall);
    assign sample_stall = skid_full_reg;
    assign accept       = sample_valid && !skid_full_reg;
    assign src_vld      = skid_full_reg || sample_valid;
    assign src          = skid_full_reg ? skid_reg : sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else if (adv)
            skid_full_reg <= 1'b0;
        else if (accept)
            skid_full_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!adv && accept)
            skid_reg <= sample;
    end

    gss_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (src_vld),
        .in_smp  (src),
        .cfg     (cfg_reg),
        .out_vld (h_vld[0]),
        .out_ctx (h_ctx[0])
    );

    assign h_p[0] = Q30_ONE;

    for (genvar g = 0; g < HORNER_N; g++)
    begin : g_horner
        gss_hstep #(.N(HORNER_N - g)) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (h_vld[g]),
            .in_ctx  (h_ctx[g]),
            .in_p    (h_p[g]),
            .out_vld (h_vld[g+1]),
            .out_ctx (h_ctx[g+1]),
            .out_p   (h_p[g+1])
        );
    end

    always_comb
    begin
        d_eff = (cfg_reg.depth > DEPTH_MAX) ? DEPTH_MAX : cfg_reg.depth;
        de_c  = 47'(d_eff) * 47'(e_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg  <= 1'b0;
            de_vld_reg <= 1'b0;
            v_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            e_vld_reg  <= h_vld[HORNER_N];
            de_vld_reg <= e_vld_reg;
            v_vld_reg  <= de_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg      <= h_ctx[HORNER_N].zero ? '0 : (h_p[HORNER_N] >> h_ctx[HORNER_N].k);
            e_tag_reg  <= h_ctx[HORNER_N].tag;
            de_reg     <= de_c[45:14];
            de_tag_reg <= e_tag_reg;
            v_reg      <= (de_reg > 32'(Q30_ONE)) ? 31'(de_reg - 32'(Q30_ONE))
                                                 : 31'(32'(Q30_ONE) - de_reg);
            v_tag_reg  <= de_tag_reg;
        end
    end

    assign sq_vld[0]  = v_vld_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_v[0]    = v_reg;
    assign sq_tag[0]  = v_tag_reg;

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sqrt
        gss_sqstep #(.I(g)) u_sq (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_vld   (sq_vld[g]),
            .in_rem   (sq_rem[g]),
            .in_root  (sq_root[g]),
            .in_v     (sq_v[g]),
            .in_tag   (sq_tag[g]),
            .out_vld  (sq_vld[g+1]),
            .out_rem  (sq_rem[g+1]),
            .out_root (sq_root[g+1]),
            .out_v    (sq_v[g+1]),
            .out_tag  (sq_tag[g+1])
        );
    end

    gss_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (sq_vld[SQ_STEPS]),
        .in_cc    (sq_root[SQ_STEPS]),
        .in_tag   (sq_tag[SQ_STEPS]),
        .out_vld  (result_valid),
        .out_data (result)
    );

    `ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_full_reg && adv, !skid_full_reg)
    `ASSERT_NEXT(a_skid_fill, clk, rst_n, !adv && accept, skid_full_reg && (skid_reg == $past(sample)))
    `ASSERT_IMPL(a_cc_range, clk, rst_n, sq_vld[SQ_STEPS], sq_root[SQ_STEPS] <= Q30_ONE)
    `ASSERT_IMPL(a_sqrt_rem, clk, rst_n, sq_vld[SQ_STEPS], sq_rem[SQ_STEPS] <= {2'b00, sq_root[SQ_STEPS], 1'b0})

endmodule

/* sim/gaussian_screen_field_scaler_tb.sv */
module gaussian_screen_field_scaler_tb;
    import gss_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned LN2_Q30_L = 64'd744261118;

    class screen_scoreboard;
        logic [GRID_W-1:0] grid;
        logic [SHIFT_W-1:0] xs, ys;
        logic [SCALE_W-1:0] scale;
        logic [DEPTH_W-1:0] dep;
        int unsigned row, col;
        out_t pending[$];
        int errors;

        function new();
            grid = CFG_RESET.grid_size;
            xs = CFG_RESET.x_shift;
            ys = CFG_RESET.y_shift;
            scale = CFG_RESET.exp_scale;
            dep = CFG_RESET.depth;
            row = 0;
            col = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                REG_GRID_SIZE: grid = d[GRID_W-1:0];
                REG_X_SHIFT:   xs = d[SHIFT_W-1:0];
                REG_Y_SHIFT:   ys = d[SHIFT_W-1:0];
                REG_EXP_SCALE: scale = d;
                REG_DEPTH:     dep = d[DEPTH_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned exp_neg(longint unsigned t24);
            longint unsigned t30, k, r, p;
            if (t24 > (64'd16 << 24))
                return 0;
            t30 = t24 << 6;
            k = t30 / LN2_Q30_L;
            r = t30 - k * LN2_Q30_L;
            p = ONE_Q30;
            for (int n = HORNER_N; n >= 1; n--)
                p = ONE_Q30 - ((r * p) >> 30) / n;
            if (k >= 31)
                return 0;
            return p >> k;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function logic [SAMPLE_W-1:0] attenuate(logic signed [SAMPLE_W-1:0] s,
                                                longint unsigned cc);
            longint unsigned mag, q;
            mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
            q = (mag * cc + (64'd1 << 29)) >> 30;
            return (s < 0) ? SAMPLE_W'(-q) : SAMPLE_W'(q);
        endfunction

        function void note_sample(in_t smp);
            longint n, half, x, y;
            longint unsigned s, t24, e, de, v, cc, d;
            bit last_col, last_row;
            out_t res;
            n = longint'(grid);
            if (n < 2) n = 2;
            if (n > GRID_MAX) n = GRID_MAX;
            d = 64'((dep > DEPTH_MAX) ? DEPTH_MAX : dep);
            half = n / 2;
            x = (longint'(row) - half) * 256 - longint'($signed(xs));
            y = (longint'(col) - half) * 256 - longint'($signed(ys));
            s = x * x + y * y;
            t24 = s * (scale >> 16) + ((s * (scale & 32'hFFFF)) >> 16);
            e = exp_neg(t24);
            de = (d * e) >> 14;
            v = (de > ONE_Q30) ? de - ONE_Q30 : ONE_Q30 - de;
            cc = root(v << 30);
            last_col = col >= n - 1;
            last_row = row >= n - 1;
            res.out_re = attenuate(smp.sample_re, cc);
            res.out_im = attenuate(smp.sample_im, cc);
            res.frame_end = last_col && last_row;
            pending.push_back(res);
            if (last_col)
            begin
                col = 0;
                row = last_row ? 0 : row + 1;
            end
            else
                col++;
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: re=%0d im=%0d end=%0b",
                             got.out_re, got.out_im, got.frame_end);
                return;
            end
            want = pending.pop_front();
            if (got.out_re !== want.out_re || got.out_im !== want.out_im
                || got.frame_end !== want.frame_end)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: want re=%0d im=%0d end=%0b, got re=%0d im=%0d end=%0b",
                             want.out_re, want.out_im, want.frame_end,
                             got.out_re, got.out_im, got.frame_end);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    in_t sample;
    logic result_valid;
    logic result_stall = 1'b0;
    out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    screen_scoreboard sb;
    logic smp_fire;
    logic cfg_fire;
    int send_idle;
    int recv_stall;
    int cycles = 0;

    gaussian_screen_field_scaler dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            smp_fire <= 1'b0;
            cfg_fire <= 1'b0;
        end
        else
        begin
            smp_fire <= sample_valid && !sample_stall;
            cfg_fire <= cfg_valid && cfg_ready;
            if (sample_valid && !sample_stall)
                sb.note_sample(sample);
            if (result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < recv_stall);

    task automatic send_sample(logic [SAMPLE_W-1:0] re, logic [SAMPLE_W-1:0] im);
        in_t v;
        v.sample_re = re;
        v.sample_im = im;
        while ($urandom_range(0, 99) < send_idle)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= v;
        @(negedge clk);
        while (!smp_fire)
            @(negedge clk);
    endtask

    task automatic send_random(int count);
        logic [SAMPLE_W-1:0] re, im;
        for (int i = 0; i < count; i++)
        begin
            re = SAMPLE_W'($urandom());
            im = SAMPLE_W'($urandom());
            // bias some beats toward full-scale and near-zero values
            case ($urandom_range(0, 7))
                0: re = {1'b1, {(SAMPLE_W-1){1'b0}}};
                1: im = {1'b0, {(SAMPLE_W-1){1'b1}}};
                2: re = SAMPLE_W'($urandom_range(0, 3) - 2);
                default: ;
            endcase
            send_sample(re, im);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
        while (!cfg_fire)
            @(negedge clk);
        sb.write_reg(idx, d);
    endtask

    task automatic apply_config(logic [31:0] n, int xsh, int ysh, logic [31:0] sc,
                                logic [31:0] dp);
        write_reg(REG_GRID_SIZE, n);
        write_reg(REG_X_SHIFT, xsh);
        write_reg(REG_Y_SHIFT, ysh);
        write_reg(REG_EXP_SCALE, sc);
        write_reg(REG_DEPTH, dp);
        cfg_valid <= 1'b0;
    endtask

    // hold off the sender until every result is back, then let the pipe settle
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_config();
        int n, span;
        logic [31:0] sc, dp;
        int xsh, ysh;
        case ($urandom_range(0, 11))
            0: n = $urandom_range(0, 1);
            1: n = 2047;
            2: n = GRID_MAX;
            default: n = $urandom_range(2, 12);
        endcase
        span = ((n < 2) ? 2 : (n > GRID_MAX ? GRID_MAX : n)) * 256;
        if ($urandom_range(0, 5) == 0)
        begin
            xsh = $urandom();
            ysh = $urandom();
        end
        else
        begin
            xsh = int'($urandom_range(0, 2 * span)) - span;
            ysh = int'($urandom_range(0, 2 * span)) - span;
        end
        case ($urandom_range(0, 5))
            0: sc = $urandom();
            1: sc = 0;
            2: sc = 32'hFFFF_FFFF;
            default: sc = $urandom_range(0, 32'h0400_0000);
        endcase
        case ($urandom_range(0, 5))
            0: dp = 32'(DEPTH_MAX);
            1: dp = 0;
            2: dp = $urandom_range(DEPTH_MAX, 16'hFFFF);
            default: dp = $urandom_range(0, DEPTH_MAX);
        endcase
        apply_config(n, xsh, ysh, sc, dp);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_GRID_SIZE;
        cfg_data = '0;
        send_idle = 0;
        recv_stall = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, extreme samples
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, {1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample('0, '1);
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, {1'b1, {(SAMPLE_W-1){1'b0}}});
        send_sample(24'd1, -24'sd1);
        drain();

        // undersized grid, depth above two and at two, zero and full scale, extreme shifts
        apply_config(0, -524288, 524287, 0, 32'hFFFF);
        send_random(4);
        drain();
        apply_config(1, 524287, -524288, 32'hFFFF_FFFF, 32'(DEPTH_MAX));
        send_random(3);
        drain();

        // shrink the grid mid-frame so the counters sit beyond it
        apply_config(8, 0, 0, 32'h0040_0000, 32'(DEPTH_MAX));
        send_random(20);
        drain();
        for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
            write_reg(CFG_IDX_W'(i), $urandom());
        write_reg(REG_GRID_SIZE, 3);
        cfg_valid <= 1'b0;
        send_random(12);
        drain();

        // oversized grid, depth zero
        apply_config(2047, 128, -128, 32'h0100_0000, 0);
        send_random(4);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 58; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 58; end
                default: begin send_idle = 8; recv_stall = 8; end
            endcase
            for (int c = 0; c < 5; c++)
            begin
                random_config();
                send_random($urandom_range(40, 90));
                drain();
            end
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
